@@ rtl/core/rgb_to_packed_pixel_converter_top_defines.svh @@
// Assertion macros shared by the converter RTL
`ifndef RGB_TO_PACKED_PIXEL_CONVERTER_TOP_DEFINES_SVH
`define RGB_TO_PACKED_PIXEL_CONVERTER_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define RPP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check an implication at every clock edge, reset included.
`define RPP_ASSERT_IMPLY(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/rpp_pkg.sv @@
// Shared types, constants and helpers of the packed pixel converter
package rpp_pkg;

   localparam int SRC_BYTE_W    = 8;
   localparam int DST_ADDR_W    = 24;
   localparam int WORD_W        = 32;
   localparam int COUNT_W       = 3;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int SHIFTS_W      = 20;
   localparam int LOSSES_W      = 16;
   localparam int ROW_PIXELS_W  = 16;
   localparam int PITCH_REG_W   = 16;
   localparam int SPAN_W        = ROW_PIXELS_W + 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_SHIFTS = 3'd0,
      CSR_CHANNEL_LOSSES = 3'd1,
      CSR_ALPHA_FILL     = 3'd2,
      CSR_SOURCE_BYTES   = 3'd3,
      CSR_DEST_BYTES     = 3'd4,
      CSR_ROW_PIXELS     = 3'd5,
      CSR_SOURCE_PITCH   = 3'd6,
      CSR_DEST_PITCH     = 3'd7
   } rpp_csr_index_type;

   typedef struct packed {
      logic [SHIFTS_W-1:0]     channel_shifts;
      logic [LOSSES_W-1:0]     channel_losses;
      logic [WORD_W-1:0]       alpha_fill;
      logic [COUNT_W-1:0]      source_bytes;
      logic [COUNT_W-1:0]      dest_bytes;
      logic [ROW_PIXELS_W-1:0] row_pixels;
      logic [PITCH_REG_W-1:0]  source_pitch;
      logic [PITCH_REG_W-1:0]  dest_pitch;
   } rpp_cfg_type;

   localparam rpp_cfg_type CFG_RESET = '{
      channel_shifts: '0,
      channel_losses: '0,
      alpha_fill:     '0,
      source_bytes:   3'd3,
      dest_bytes:     3'd4,
      row_pixels:     16'd1,
      source_pitch:   16'd3,
      dest_pitch:     16'd4
   };

   // One packed pixel on its way to the serializer
   typedef struct packed {
      logic [WORD_W-1:0]  word;
      logic [COUNT_W-1:0] count;
   } rpp_pixel_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rpp_queue_status_type;

   // Drop loss bits of a channel, then move it to its field
   function automatic logic [WORD_W-1:0] place(input logic [SRC_BYTE_W-1:0] value,
                                               input logic [3:0] loss,
                                               input logic [4:0] shift);
      logic [WORD_W-1:0] tmp;
      tmp = WORD_W'(value >> loss);
      return tmp << shift;
   endfunction

endpackage

@@ rtl/core/rpp_req_if.sv @@
// Source byte channel
interface rpp_req_if;
   import rpp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SRC_BYTE_W-1:0] src_byte;

   modport source (output valid, output src_byte, input ready);
   modport sink   (input valid, input src_byte, output ready);
endinterface

@@ rtl/core/rpp_rsp_if.sv @@
// Destination byte channel
interface rpp_rsp_if;
   import rpp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [DST_ADDR_W-1:0] dst_address;
   logic [SRC_BYTE_W-1:0] dst_byte;
   logic                  last_of_pixel;

   modport source (output valid, output dst_address, output dst_byte, output last_of_pixel,
                   input ready);
   modport sink   (input valid, input dst_address, input dst_byte, input last_of_pixel,
                   output ready);
endinterface

@@ rtl/core/rpp_queue.sv @@
// Two-entry queue between the pixel assembler and the byte serializer
module rpp_queue #(
   parameter int WIDTH = 59
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [WIDTH-1:0]              push_data,
   input  logic                          pop,
   output logic [WIDTH-1:0]              pop_data,
   output rpp_pkg::rpp_queue_status_type status
);
   import rpp_pkg::*;

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = data_ff[rd_ptr_ff];
   assign status.full  = count_ff[1];
   assign status.empty = (count_ff == 2'd0);

endmodule

@@ rtl/core/rpp_front.sv @@
// Pixel assembler: tracks row position, gathers channels, builds packed words
module rpp_front #(
   parameter int ADDR_BITS  = 24,
   parameter int PITCH_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rpp_pkg::rpp_cfg_type          cfg,
   rpp_req_if.sink                       req,
   input  rpp_pkg::rpp_queue_status_type q_status,
   output logic                          push,
   output logic [ADDR_BITS-1:0]          push_addr,
   output rpp_pkg::rpp_pixel_type        push_pixel
);
   import rpp_pkg::*;

   localparam int CMP_W = (PITCH_BITS > SPAN_W) ? PITCH_BITS : SPAN_W;

   logic [1:0]            chan_idx_ff, chan_idx_in;
   logic [SRC_BYTE_W-1:0] red_ff, green_ff, blue_ff;
   logic [PITCH_BITS-1:0] pos_ff, pos_in;
   logic [ADDR_BITS-1:0]  ptr_ff, ptr_in;
   logic [ADDR_BITS-1:0]  base_ff, base_in;

   logic                  accept;
   logic                  sb4;
   logic [COUNT_W-1:0]    dest_count;
   logic [SPAN_W-1:0]     span;
   logic [CMP_W-1:0]      span_ext, pitch_ext, wide_len, capped_len;
   logic [PITCH_BITS-1:0] row_len;
   logic [PITCH_BITS:0]   pos_next;
   logic                  row_end;
   logic                  in_span;
   logic                  done;
   logic [SRC_BYTE_W-1:0] blue_src;
   logic [WORD_W-1:0]     color_word;
   logic [WORD_W-1:0]     alpha_word;
   logic [ADDR_BITS-1:0]  next_base;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   // Row geometry from the configuration
   always_comb begin
      sb4  = (cfg.source_bytes == 3'd4);
      span = sb4 ? {cfg.row_pixels, 2'b00}
                 : ({1'b0, cfg.row_pixels, 1'b0} + {2'b00, cfg.row_pixels});
      span_ext   = CMP_W'(span);
      pitch_ext  = CMP_W'(cfg.source_pitch);
      wide_len   = (pitch_ext > span_ext) ? pitch_ext : span_ext;
      capped_len = (wide_len > CMP_W'({PITCH_BITS{1'b1}})) ? CMP_W'({PITCH_BITS{1'b1}})
                                                            : wide_len;
      row_len    = (capped_len == '0) ? PITCH_BITS'(1) : PITCH_BITS'(capped_len);
      pos_next   = {1'b0, pos_ff} + (PITCH_BITS+1)'(1);
      row_end    = (pos_next >= {1'b0, row_len});
      in_span    = (CMP_W'(pos_ff) < span_ext);
      if (cfg.dest_bytes == 3'd0) begin
         dest_count = 3'd1;
      end else if (cfg.dest_bytes > 3'd4) begin
         dest_count = 3'd4;
      end else begin
         dest_count = cfg.dest_bytes;
      end
   end

   // Channel capture and pixel completion
   always_comb begin
      case (chan_idx_ff)
         2'd2:    done = !sb4;
         2'd3:    done = 1'b1;
         default: done = 1'b0;
      endcase
      blue_src   = (chan_idx_ff == 2'd2) ? req.src_byte : blue_ff;
      color_word = place(red_ff,   cfg.channel_losses[3:0],   cfg.channel_shifts[4:0])
                 | place(green_ff, cfg.channel_losses[7:4],   cfg.channel_shifts[9:5])
                 | place(blue_src, cfg.channel_losses[11:8],  cfg.channel_shifts[14:10]);
      alpha_word = sb4 ? (place(req.src_byte, cfg.channel_losses[15:12],
                                cfg.channel_shifts[19:15]) & cfg.alpha_fill)
                       : cfg.alpha_fill;
      push             = accept && in_span && done;
      push_addr        = ptr_ff;
      push_pixel.word  = color_word | alpha_word;
      push_pixel.count = dest_count;
   end

   // Position, channel index and destination pointers
   always_comb begin
      chan_idx_in = chan_idx_ff;
      pos_in      = pos_ff;
      ptr_in      = ptr_ff;
      base_in     = base_ff;
      next_base   = base_ff + ADDR_BITS'(cfg.dest_pitch);
      if (accept) begin
         if (in_span) begin
            if (done) begin
               chan_idx_in = 2'd0;
               ptr_in      = ptr_ff + ADDR_BITS'(dest_count);
            end else begin
               chan_idx_in = chan_idx_ff + 2'd1;
            end
         end
         if (row_end) begin
            pos_in      = '0;
            chan_idx_in = 2'd0;
            base_in     = next_base;
            ptr_in      = next_base;
         end else begin
            pos_in = PITCH_BITS'(pos_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_idx_ff <= 2'd0;
         pos_ff      <= '0;
         ptr_ff      <= '0;
         base_ff     <= '0;
         red_ff      <= '0;
         green_ff    <= '0;
         blue_ff     <= '0;
      end else begin
         chan_idx_ff <= chan_idx_in;
         pos_ff      <= pos_in;
         ptr_ff      <= ptr_in;
         base_ff     <= base_in;
         if (accept && in_span) begin
            case (chan_idx_ff)
               2'd0:    red_ff   <= req.src_byte;
               2'd1:    green_ff <= req.src_byte;
               2'd2:    blue_ff  <= req.src_byte;
               default: ;
            endcase
         end
      end
   end

endmodule

@@ rtl/core/rpp_back.sv @@
// Byte serializer: sends each packed word least significant byte first
module rpp_back #(
   parameter int ADDR_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rpp_pkg::rpp_queue_status_type q_status,
   input  logic [ADDR_BITS-1:0]          pop_addr,
   input  rpp_pkg::rpp_pixel_type        pop_pixel,
   output logic                          pop,
   rpp_rsp_if.source                     rsp
);
   import rpp_pkg::*;

   logic                  active_ff, active_in;
   logic [ADDR_BITS-1:0]  addr_ff;
   logic [WORD_W-1:0]     word_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [1:0]            idx_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [DST_ADDR_W-1:0] out_addr_ff;
   logic [SRC_BYTE_W-1:0] out_byte_ff;
   logic                  out_last_ff;

   logic                  out_free;
   logic                  emit;
   logic                  is_last;

   always_comb begin
      out_free = !out_valid_ff || rsp.ready;
      emit     = active_ff && out_free;
      is_last  = ({1'b0, idx_ff} + 3'd1 == count_ff);
      pop      = !q_status.empty && (!active_ff || (emit && is_last));
      active_in = active_ff;
      if (pop) begin
         active_in = 1'b1;
      end else if (emit && is_last) begin
         active_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         addr_ff  <= pop_addr;
         word_ff  <= pop_pixel.word;
         count_ff <= pop_pixel.count;
         idx_ff   <= 2'd0;
      end else if (emit) begin
         addr_ff <= addr_ff + ADDR_BITS'(1);
         idx_ff  <= idx_ff + 2'd1;
      end
      if (emit) begin
         out_addr_ff <= DST_ADDR_W'(addr_ff);
         out_byte_ff <= word_ff[{idx_ff, 3'b000} +: SRC_BYTE_W];
         out_last_ff <= is_last;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.dst_address   = out_addr_ff;
   assign rsp.dst_byte      = out_byte_ff;
   assign rsp.last_of_pixel = out_last_ff;

endmodule

@@ rtl/core/rgb_to_packed_pixel_converter_top.sv @@
// Top level of the RGB(A) byte stream to packed pixel converter
//
// req_chan carries the source image one byte per word, in address order;
// rows of row_pixels pixels (3 or 4 bytes each) followed by padding that is
// dropped. rsp_chan returns each packed pixel as dest_bytes words (clamped to 1 to 4), least
// significant byte first, each with its destination byte address and a flag
// on the pixel's final byte. The csr_ port writes one register per cycle.
//
// Throughput: one source word per cycle while the pixel queue is not full;
// one result word per cycle from the single byte lane of the serializer,
// while the receiver is ready.
// A pixel's last source byte passes the queue write, then the serializer load,
// then the output register before the pixel's first byte is valid.
//
// Reset (synchronous, active high) restores register defaults, clears the
// row position, pointers and queue, and drops any word in flight.
// A stalled receiver holds the output register; the two-entry pixel queue
// keeps taking source bytes until it fills, then req_chan.ready drops.
`include "rgb_to_packed_pixel_converter_top_defines.svh"

module rgb_to_packed_pixel_converter_top #(
   parameter int ADDR_BITS  = 24,
   parameter int PITCH_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   rpp_req_if.sink                          req_chan,
   rpp_rsp_if.source                        rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [rpp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rpp_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import rpp_pkg::*;

   localparam int QUEUE_W = ADDR_BITS + $bits(rpp_pixel_type);

   rpp_cfg_type          cfg_ff, cfg_in;
   rpp_queue_status_type q_status;
   logic                 push, pop;
   logic [ADDR_BITS-1:0] push_addr, pop_addr;
   rpp_pixel_type        push_pixel, pop_pixel;
   logic [QUEUE_W-1:0]   pop_data;

   // Register file: hold every value until the next write to its index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (rpp_csr_index_type'(csr_index))
            CSR_CHANNEL_SHIFTS: cfg_in.channel_shifts = SHIFTS_W'(csr_wr_data);
            CSR_CHANNEL_LOSSES: cfg_in.channel_losses = LOSSES_W'(csr_wr_data);
            CSR_ALPHA_FILL:     cfg_in.alpha_fill     = WORD_W'(csr_wr_data);
            CSR_SOURCE_BYTES:   cfg_in.source_bytes   = COUNT_W'(csr_wr_data);
            CSR_DEST_BYTES:     cfg_in.dest_bytes     = COUNT_W'(csr_wr_data);
            CSR_ROW_PIXELS:     cfg_in.row_pixels     = ROW_PIXELS_W'(csr_wr_data);
            CSR_SOURCE_PITCH:   cfg_in.source_pitch   = PITCH_REG_W'(csr_wr_data);
            CSR_DEST_PITCH:     cfg_in.dest_pitch     = PITCH_REG_W'(csr_wr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: take source words, assemble pixels, advance destination pointers
   rpp_front #(
      .ADDR_BITS  (ADDR_BITS),
      .PITCH_BITS (PITCH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_chan),
      .q_status   (q_status),
      .push       (push),
      .push_addr  (push_addr),
      .push_pixel (push_pixel)
   );

   // Queue: decouple pixel assembly from byte output
   rpp_queue #(
      .WIDTH (QUEUE_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_addr, push_pixel}),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   assign pop_addr  = pop_data[QUEUE_W-1 -: ADDR_BITS];
   assign pop_pixel = rpp_pixel_type'(pop_data[$bits(rpp_pixel_type)-1:0]);

   // Back: serialize each pixel into result words behind an output register
   rpp_back #(
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_addr  (pop_addr),
      .pop_pixel (pop_pixel),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

   `RPP_ASSERT_ALWAYS(a_no_push_when_full, clock, reset, !(push && q_status.full), "pixel pushed into full queue")
   `RPP_ASSERT_ALWAYS(a_no_pop_when_empty, clock, reset, !(pop && q_status.empty), "pixel popped from empty queue")
   `RPP_ASSERT_IMPLY(a_clean_after_reset, clock, $fell(reset), q_status.empty && !rsp_chan.valid, "state not cleared by reset")

endmodule
